// File: hw/rtl/shp_pkg.sv
// shared types, constants and round functions of the sha-256 hasher
package shp_pkg;

  typedef enum logic [2:0] {
    F_IDLE,
    F_BYTES,
    F_PAD,
    F_ZERO,
    F_LEN
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_ADD,
    B_OUT
  } back_state_e;

  typedef struct packed {
    logic              last;
    logic [15:0][31:0] data;
  } block_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  localparam logic [5:0] LenFill = 6'd56;
  localparam logic [2:0] MaxBytes = 3'd4;
  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6A09E667;
      3'd1: r = 32'hBB67AE85;
      3'd2: r = 32'h3C6EF372;
      3'd3: r = 32'hA54FF53A;
      3'd4: r = 32'h510E527F;
      3'd5: r = 32'h9B05688C;
      3'd6: r = 32'h1F83D9AB;
      default: r = 32'h5BE0CD19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] r;
    case (i)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;  6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5;  6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;  6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01;  6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// File: hw/rtl/shp_front.sv
// front end: byte packing, padding and length append into 512-bit blocks
module shp_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [31:0]             message_word_i,
  input  logic [2:0]              valid_bytes_i,
  input  logic                    is_last_i,
  input  shp_pkg::queue_stat_t    q_stat_i,
  output logic                    push_o,
  output shp_pkg::block_job_t     job_o
);

  shp_pkg::front_state_e state_q, state_d;
  logic [31:0]       word_q;
  logic [2:0]        cnt_q;
  logic              last_q;
  logic [5:0]        fill_q;
  logic              full_q;
  logic              blast_q;
  logic [63:0]       len_q;
  logic [15:0][31:0] buf_q;

  logic       accept;
  logic       wr_en;
  logic       take;
  logic       len_wr;
  logic [7:0] wr_byte;
  logic [1:0] bsel;

  assign in_stall_o = (state_q != shp_pkg::F_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = full_q && !q_stat_i.full;
  assign job_o.last = blast_q;
  assign job_o.data = buf_q;
  assign bsel       = 2'd3 - fill_q[1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      shp_pkg::F_IDLE: begin
        if (accept) state_d = shp_pkg::F_BYTES;
      end
      shp_pkg::F_BYTES: begin
        if (!full_q && cnt_q == 3'd0) state_d = last_q ? shp_pkg::F_PAD : shp_pkg::F_IDLE;
      end
      shp_pkg::F_PAD: begin
        if (!full_q) state_d = shp_pkg::F_ZERO;
      end
      shp_pkg::F_ZERO: begin
        if (!full_q && fill_q == shp_pkg::LenFill) state_d = shp_pkg::F_LEN;
      end
      shp_pkg::F_LEN: begin
        if (!full_q) state_d = shp_pkg::F_IDLE;
      end
      default: state_d = shp_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    take    = 1'b0;
    len_wr  = 1'b0;
    wr_byte = 8'h00;
    case (state_q)
      shp_pkg::F_BYTES: begin
        if (!full_q && cnt_q != 3'd0) begin
          wr_en   = 1'b1;
          take    = 1'b1;
          wr_byte = word_q[31:24];
        end
      end
      shp_pkg::F_PAD: begin
        if (!full_q) begin
          wr_en   = 1'b1;
          wr_byte = shp_pkg::PadByte;
        end
      end
      shp_pkg::F_ZERO: begin
        if (!full_q && fill_q != shp_pkg::LenFill) wr_en = 1'b1;
      end
      shp_pkg::F_LEN: begin
        if (!full_q) len_wr = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= shp_pkg::F_IDLE;
      cnt_q   <= 3'd0;
      last_q  <= 1'b0;
      fill_q  <= 6'd0;
      full_q  <= 1'b0;
      blast_q <= 1'b0;
      len_q   <= 64'd0;
    end else begin
      state_q <= state_d;
      if (push_o) full_q <= 1'b0;
      if (accept) begin
        cnt_q  <= (valid_bytes_i > shp_pkg::MaxBytes) ? shp_pkg::MaxBytes : valid_bytes_i;
        last_q <= is_last_i;
      end
      if (take) begin
        cnt_q <= cnt_q - 3'd1;
        len_q <= len_q + 64'd8;
      end
      if (wr_en) begin
        fill_q <= fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          full_q  <= 1'b1;
          blast_q <= 1'b0;
        end
      end
      if (len_wr) begin
        full_q  <= 1'b1;
        blast_q <= 1'b1;
        fill_q  <= 6'd0;
        len_q   <= 64'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) word_q <= message_word_i;
    if (take) word_q <= {word_q[23:0], 8'h00};
    if (wr_en) buf_q[fill_q[5:2]][{bsel, 3'b000} +: 8] <= wr_byte;
    if (len_wr) begin
      buf_q[14] <= len_q[63:32];
      buf_q[15] <= len_q[31:0];
    end
  end

endmodule

// File: hw/rtl/shp_queue.sv
// short block queue between the front end and the compression engine
module shp_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  shp_pkg::block_job_t  job_i,
  input  logic                 pop_i,
  output shp_pkg::block_job_t  job_o,
  output shp_pkg::queue_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  shp_pkg::block_job_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign job_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      if (pop_i) rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

endmodule

// File: hw/rtl/shp_back.sv
// back end: 64-round compression, chaining update and digest output
module shp_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  shp_pkg::queue_stat_t q_stat_i,
  input  shp_pkg::block_job_t  job_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [31:0]          digest_word_o,
  output logic [2:0]           word_index_o,
  output logic                 run_end_o
);

  shp_pkg::back_state_e state_q, state_d;
  logic [7:0][31:0]  h_q;
  logic [7:0][31:0]  v_q;
  logic [15:0][31:0] w_q;
  logic [5:0]        rnd_q;
  logic              last_q;
  logic [2:0]        idx_q;

  logic        do_round, do_add, out_xfer;
  logic [31:0] t1, t2, w_new;

  always_comb begin
    state_d = state_q;
    case (state_q)
      shp_pkg::B_IDLE: begin
        if (!q_stat_i.empty) state_d = shp_pkg::B_RUN;
      end
      shp_pkg::B_RUN: begin
        if (rnd_q == 6'd63) state_d = shp_pkg::B_ADD;
      end
      shp_pkg::B_ADD: state_d = last_q ? shp_pkg::B_OUT : shp_pkg::B_IDLE;
      shp_pkg::B_OUT: begin
        if (!out_stall_i && idx_q == 3'd7) state_d = shp_pkg::B_IDLE;
      end
      default: state_d = shp_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = (state_q == shp_pkg::B_IDLE) && !q_stat_i.empty;
    do_round    = (state_q == shp_pkg::B_RUN);
    do_add      = (state_q == shp_pkg::B_ADD);
    out_valid_o = (state_q == shp_pkg::B_OUT);
    out_xfer    = out_valid_o && !out_stall_i;
  end

  assign digest_word_o = h_q[idx_q];
  assign word_index_o  = idx_q;
  assign run_end_o     = (idx_q == 3'd7);

  always_comb begin
    t1 = v_q[7] + shp_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + shp_pkg::round_k(rnd_q) + w_q[0];
    t2 = shp_pkg::bsig0(v_q[0])
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_new = shp_pkg::ssig1(w_q[14]) + w_q[9] + shp_pkg::ssig0(w_q[1]) + w_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= shp_pkg::B_IDLE;
      rnd_q   <= 6'd0;
      last_q  <= 1'b0;
      idx_q   <= 3'd0;
      for (int i = 0; i < 8; i++) h_q[i] <= shp_pkg::init_hash(3'(i));
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        rnd_q  <= 6'd0;
        last_q <= job_i.last;
      end
      if (do_round) rnd_q <= rnd_q + 6'd1;
      if (do_add) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (out_xfer) begin
        idx_q <= idx_q + 3'd1;
        if (idx_q == 3'd7) begin
          for (int i = 0; i < 8; i++) h_q[i] <= shp_pkg::init_hash(3'(i));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      v_q <= h_q;
      w_q <= job_i.data;
    end
    if (do_round) begin
      v_q <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
      w_q <= {w_new, w_q[15:1]};
    end
  end

endmodule

// File: hw/rtl/sha256_message_hasher_top.sv
// top level of the streaming sha-256 message hasher
//
// input channel: message_word_i with valid_bytes_i (0..4, counted from bit 31
// down, 5..7 taken as 4) and is_last_i; a transfer happens when in_valid_i is
// high and in_stall_o is low. the front end takes one byte per cycle unless a
// finished block waits for room in the queue, and in_stall_o stays high until
// all bytes of the word are taken. every 64 bytes form a block that goes to a
// block queue of QueueDepth entries; the compression engine does one round per
// cycle, faster than the front end fills a block, so the front end sets the
// sustained rate. on the final word the front end pads with 0x80, zeros (one
// byte per cycle unless a finished block waits) and the 64-bit bit length,
// using an extra block if needed.
// output channel: eight transfers digest_word_o for H0..H7 with word_index_o,
// run_end_o high on H7; a transfer happens when out_valid_o is high and
// out_stall_i is low. while the receiver stalls the digest word holds and the
// front end keeps packing until the queue is full.
// H0 follows the final word once its padding and all remaining blocks are done.
// reset empties the queue, clears length and fill and loads the initial hash.
module sha256_message_hasher_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] message_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        run_end_o
);

  shp_pkg::queue_stat_t q_stat;
  shp_pkg::block_job_t  job_in, job_out;
  logic push, pop;

  shp_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .message_word_i, .valid_bytes_i,
    .is_last_i, .q_stat_i(q_stat), .push_o(push), .job_o(job_in)
  );

  shp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .job_i(job_in), .pop_i(pop),
    .job_o(job_out), .stat_o(q_stat)
  );

  shp_back u_back (
    .clk_i, .rst_ni, .q_stat_i(q_stat), .job_i(job_out), .pop_o(pop),
    .out_valid_o, .out_stall_i, .digest_word_o, .word_index_o, .run_end_o
  );

endmodule

// File: hw/rtl/shp_checker.sv
// port-level checker of the hasher output sequence, bound to the top level
module shp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        run_end_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_word_o)
      && $stable(word_index_o))
    else $error("stalled digest word changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (run_end_o == (word_index_o == 3'd7)))
    else $error("run_end does not match word index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_end_o |=>
      out_valid_o && word_index_o == $past(word_index_o) + 3'd1)
    else $error("digest words not in sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && run_end_o |=> !out_valid_o || word_index_o == 3'd0)
    else $error("digest run did not restart at h0");

endmodule

bind sha256_message_hasher_top shp_checker u_shp_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .digest_word_o, .word_index_o, .run_end_o
);

// File: tb/tb_sha256_message_hasher_top.sv
// testbench of the streaming sha-256 message hasher with a scoreboard class and random stalls
`timescale 1ns / 1ps

module tb_sha256_message_hasher_top;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_exp_t;

  class digest_scoreboard;
    logic [31:0] chain[8];
    logic [7:0]  block_bytes[64];
    int unsigned fill;
    logic [63:0] msg_bits;
    digest_exp_t digest_q[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = 32'h6A09E667; chain[1] = 32'hBB67AE85;
      chain[2] = 32'h3C6EF372; chain[3] = 32'hA54FF53A;
      chain[4] = 32'h510E527F; chain[5] = 32'h9B05688C;
      chain[6] = 32'h1F83D9AB; chain[7] = 32'h5BE0CD19;
      foreach (block_bytes[i]) block_bytes[i] = 8'h00;
      fill = 0;
      msg_bits = 64'd0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] kc[64];
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2;
      kc = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
             32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
             32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
             32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
             32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
             32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
             32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
             32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
             32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
             32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
             32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
             32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
             32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      for (int i = 0; i < 16; i++)
        w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 64; i++)
        w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
             + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kc[i] + w[i];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
      foreach (block_bytes[i]) block_bytes[i] = 8'h00;
      fill = 0;
    endfunction

    function void add_byte(logic [7:0] b);
      block_bytes[fill] = b;
      fill++;
      if (fill == 64) compress();
    endfunction

    function void note_word(logic [31:0] word, logic [2:0] nbytes, logic last);
      int unsigned n;
      digest_exp_t e;
      n = (nbytes > 3'd4) ? 4 : nbytes;
      for (int i = 0; i < n; i++) begin
        add_byte(word[31 - 8*i -: 8]);
        msg_bits += 64'd8;
      end
      if (last) begin
        add_byte(8'h80);
        if (fill > 56) while (fill != 0) add_byte(8'h00);
        while (fill < 56) add_byte(8'h00);
        for (int i = 0; i < 8; i++) add_byte(msg_bits[63 - 8*i -: 8]);
        for (int i = 0; i < 8; i++) begin
          e.word = chain[i];
          e.index = i[2:0];
          e.last = (i == 7);
          digest_q.push_back(e);
        end
        restart();
      end
    endfunction

    function void check_digest(logic [31:0] word, logic [2:0] index, logic last);
      digest_exp_t e;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest transfer: word %h index %0d end %b", word, index, last);
        return;
      end
      e = digest_q.pop_front();
      if (word !== e.word || index !== e.index || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                   e.word, e.index, e.last, word, index, last);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] message_word_i = '0;
  logic [2:0]  valid_bytes_i = '0;
  logic        is_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        run_end_o;

  digest_scoreboard sb = new();
  bit burst = 0;
  bit quiet = 0;
  bit held = 0;
  int unsigned digests_seen = 0;
  int unsigned idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  sha256_message_hasher_top dut (.*);

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 5000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic put_word(logic [31:0] word, logic [2:0] nbytes, logic last);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    message_word_i = word;
    valid_bytes_i = nbytes;
    is_last_i = last;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(word, nbytes, last);
    @(negedge clk_i);
  endtask

  task automatic put_message(int unsigned nwords);
    logic [2:0] nb;
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < nwords; i++) begin
      nb = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
      put_word($urandom, nb, 1'b0);
    end
    nb = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4));
    put_word($urandom, nb, 1'b1);
  endtask

  initial begin
    int unsigned n;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) continue;
      if (!held && digests_seen >= 16) begin
        held = 1;
        out_stall_i = 1'b1;
        repeat (800) @(negedge clk_i);
      end
      n = quiet ? 0 : $urandom_range(0, 8);
      out_stall_i = (n != 0);
      repeat (n) @(negedge clk_i);
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_digest(digest_word_o, word_index_o, run_end_o);
      digests_seen++;
      if (digests_seen % 32 == 0) quiet = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int unsigned items;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // empty message, then "abc"
    put_word(32'h0000_0000, 3'd0, 1'b1);
    put_word(32'h6162_6300, 3'd3, 1'b1);
    // all ones with oversized byte counts
    put_word(32'hFFFF_FFFF, 3'd5, 1'b0);
    put_word(32'hFFFF_FFFF, 3'd6, 1'b0);
    put_word(32'hFFFF_FFFF, 3'd7, 1'b1);
    // short words before the end, ignored low bits, empty final word
    put_word(32'h12FF_FFFF, 3'd1, 1'b0);
    put_word(32'h3456_78FF, 3'd3, 1'b0);
    put_word(32'h9ABC_DEF0, 3'd2, 1'b0);
    put_word(32'hDEAD_BEEF, 3'd0, 1'b1);
    // 56 bytes forces an extra padding block
    for (int i = 0; i < 13; i++) put_word(32'h0000_0000, 3'd4, 1'b0);
    put_word(32'h0102_0304, 3'd4, 1'b1);
    items = 0;
    while (items < 95) begin
      n_words: begin
        int unsigned len;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 20) : $urandom_range(0, 12);
        put_message(len);
        items += len + 1;
      end
    end
    in_valid_i = 1'b0;
    while (sb.digest_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.digest_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/shp_pkg.sv
hw/rtl/shp_front.sv
hw/rtl/shp_queue.sv
hw/rtl/shp_back.sv
hw/rtl/sha256_message_hasher_top.sv
hw/rtl/shp_checker.sv
tb/tb_sha256_message_hasher_top.sv
